// ===== rtl/smam_pkg.sv =====
// ----------------------------------------------------------------------------
// smam_pkg
// Shared types and codes for the multi-slot alarm matcher.
// ----------------------------------------------------------------------------
package smam_pkg;

  localparam int HOUR_W = 5;
  localparam int MIN_W  = 6;
  localparam int SEC_W  = 6;
  localparam int IDX_W  = 4;
  localparam int CNT_W  = 4;
  localparam int OP_W   = 3;
  localparam int STAT_W = 2;

  localparam logic [OP_W-1:0] OP_ADD     = 3'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd1;
  localparam logic [OP_W-1:0] OP_ENABLE  = 3'd2;
  localparam logic [OP_W-1:0] OP_DISABLE = 3'd3;
  localparam logic [OP_W-1:0] OP_CHECK   = 3'd4;
  localparam logic [OP_W-1:0] OP_DISMISS = 3'd5;

  localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

  localparam logic [IDX_W-1:0] NO_SLOT = 4'hF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK_DEL,
    ST_WALK_CHK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              enable;
    logic              rpt;
  } slot_t;

  // Write command toward the slot table.
  typedef struct packed {
    logic             wr_slot;   // write the whole entry
    logic             wr_en_bit; // write the enable bit only
    logic [IDX_W-1:0] addr;
    slot_t            data;
    logic             en_bit;
  } tbl_cmd_t;

endpackage

// ===== rtl/multi_slot_alarm_matcher.sv =====
// ----------------------------------------------------------------------------
// multi_slot_alarm_matcher
// Compacted table of alarm slots with add, delete, enable, disable,
// time check and alert dismiss.
// ----------------------------------------------------------------------------
// Pulse start with an item while busy is low; the block answers with exactly
// one result, shown for a single cycle with done high, and the receiver
// cannot stall it. Add, enable, disable, dismiss, unused codes, rejected
// items and checks that are skipped go from accept through ST_EXEC to ST_RESP.
// Delete and time check step one slot per cycle through the table's single
// read port and the one shared slot compare. Count used_slots as it stands
// when the item arrives: a delete at index i walks slots i to used_slots - 1,
// and a time check walks from slot 0 to the first match or the last used slot.
// busy stays high from accept until the cycle after done.
module multi_slot_alarm_matcher #(
  parameter int SLOT_COUNT_MAX = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [smam_pkg::OP_W-1:0]    operation,
  input  logic [smam_pkg::IDX_W-1:0]   slot_index,
  input  logic [smam_pkg::HOUR_W-1:0]  hour_value,
  input  logic [smam_pkg::MIN_W-1:0]   minute_value,
  input  logic [smam_pkg::SEC_W-1:0]   second_value,
  input  logic                         new_enabled,
  input  logic                         new_repeat,
  output logic                         done,
  output logic [smam_pkg::STAT_W-1:0]  status,
  output logic                         alert_on,
  output logic [smam_pkg::IDX_W-1:0]   fired_slot,
  output logic [smam_pkg::CNT_W-1:0]   used_slots
);
  import smam_pkg::*;

  state_t state, state_next;

  // Latched item.
  logic [OP_W-1:0]   op_r;
  logic [IDX_W-1:0]  idx_r;
  logic [HOUR_W-1:0] hr_r;
  logic [MIN_W-1:0]  mn_r;
  logic [SEC_W-1:0]  sc_r;
  logic              en_r;
  logic              rp_r;

  // Architectural state.
  logic [CNT_W-1:0]  slot_count, slot_count_next;
  logic              alert_active, alert_active_next;
  logic [IDX_W-1:0]  alert_slot, alert_slot_next;
  logic [STAT_W-1:0] stat_r, stat_next;
  logic [IDX_W-1:0]  ptr, ptr_next;

  tbl_cmd_t          cmd;
  logic [IDX_W-1:0]  rd_addr;
  slot_t             rd_slot;

  logic              accept;
  logic              in_range;
  logic              table_full;
  logic              more_after;
  logic              match;

  assign accept     = start && (state == ST_IDLE);
  assign in_range   = ({1'b0, idx_r} < {1'b0, slot_count});
  assign table_full = (slot_count >= CNT_W'(SLOT_COUNT_MAX));
  // Another slot follows the one under the pointer.
  assign more_after = (({1'b0, ptr} + 5'd1) < {1'b0, slot_count});

  // Delete reads one slot ahead of the write; check reads at the pointer.
  assign rd_addr = (state == ST_WALK_DEL) ? (ptr + IDX_W'(1)) : ptr;

  // Shared slot compare.
  assign match = rd_slot.enable && (rd_slot.hour == hr_r) &&
                 (rd_slot.minute == mn_r) && (rd_slot.second == sc_r);

  smam_slot_table #(
    .DEPTH (SLOT_COUNT_MAX)
  ) u_table (
    .clk     (clk),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .rd_data (rd_slot)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_RESP;
        if (op_r == OP_DELETE && in_range) begin
          state_next = ST_WALK_DEL;
        end else if (op_r == OP_CHECK && !alert_active && slot_count != '0) begin
          state_next = ST_WALK_CHK;
        end
      end
      ST_WALK_DEL: begin
        if (!more_after) state_next = ST_RESP;
      end
      ST_WALK_CHK: begin
        if (match || !more_after) state_next = ST_RESP;
      end
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath and table commands.
  always_comb begin
    slot_count_next   = slot_count;
    alert_active_next = alert_active;
    alert_slot_next   = alert_slot;
    stat_next         = stat_r;
    ptr_next          = ptr;
    cmd               = '0;
    cmd.addr          = ptr;
    case (state)
      ST_EXEC: begin
        stat_next = STAT_DONE;
        case (op_r)
          OP_ADD: begin
            if (table_full) begin
              stat_next = STAT_FULL;
            end else begin
              // Append at the end of the compacted table.
              cmd.wr_slot     = 1'b1;
              cmd.addr        = slot_count;
              cmd.data.hour   = hr_r;
              cmd.data.minute = mn_r;
              cmd.data.second = sc_r;
              cmd.data.enable = en_r;
              cmd.data.rpt    = rp_r;
              slot_count_next = slot_count + CNT_W'(1);
            end
          end
          OP_DELETE: begin
            if (!in_range) stat_next = STAT_RANGE;
            ptr_next = idx_r;
          end
          OP_ENABLE, OP_DISABLE: begin
            if (!in_range) begin
              stat_next = STAT_RANGE;
            end else begin
              cmd.wr_en_bit = 1'b1;
              cmd.addr      = idx_r;
              cmd.en_bit    = (op_r == OP_ENABLE);
            end
          end
          OP_CHECK: begin
            ptr_next = '0;
          end
          OP_DISMISS: begin
            alert_active_next = 1'b0;
            alert_slot_next   = NO_SLOT;
          end
          default: begin
          end
        endcase
      end
      ST_WALK_DEL: begin
        if (more_after) begin
          // Shift the next slot down into the hole.
          cmd.wr_slot = 1'b1;
          cmd.data    = rd_slot;
          ptr_next    = ptr + IDX_W'(1);
        end else begin
          slot_count_next = slot_count - CNT_W'(1);
        end
      end
      ST_WALK_CHK: begin
        if (match) begin
          alert_active_next = 1'b1;
          alert_slot_next   = ptr;
          // Drop a one-shot alarm once it fires.
          if (!rd_slot.rpt) begin
            cmd.wr_en_bit = 1'b1;
            cmd.en_bit    = 1'b0;
          end
        end else begin
          ptr_next = ptr + IDX_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slot_count   <= '0;
      alert_active <= 1'b0;
      alert_slot   <= NO_SLOT;
    end else begin
      state        <= state_next;
      slot_count   <= slot_count_next;
      alert_active <= alert_active_next;
      alert_slot   <= alert_slot_next;
    end
  end

  // Payload registers: hold the item, the walk pointer and the status.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= operation;
      idx_r <= slot_index;
      hr_r  <= hour_value;
      mn_r  <= minute_value;
      sc_r  <= second_value;
      en_r  <= new_enabled;
      rp_r  <= new_repeat;
    end
    ptr    <= ptr_next;
    stat_r <= stat_next;
  end

  assign busy       = (state != ST_IDLE);
  assign done       = (state == ST_RESP);
  assign status     = stat_r;
  assign alert_on   = alert_active;
  assign fired_slot = alert_slot;
  assign used_slots = slot_count;

  // Checks.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CNT_W'(SLOT_COUNT_MAX))
    else $error("slot count beyond table depth");

  a_alert_slot: assert property (@(posedge clk) disable iff (rst)
    !alert_active |-> (alert_slot == NO_SLOT))
    else $error("alert slot set without an active alert");

  a_alert_idx: assert property (@(posedge clk) disable iff (rst)
    alert_active |-> (alert_slot < IDX_W'(SLOT_COUNT_MAX)))
    else $error("alert slot outside the table");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done && !busy)
    else $error("result strobe longer than one cycle");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |=> $stable(slot_count))
    else $error("slot count changed without an item");

endmodule

// ===== rtl/smam_slot_table.sv =====
// ----------------------------------------------------------------------------
// smam_slot_table
// Register file of alarm slots: one read port, one write port.
// ----------------------------------------------------------------------------
module smam_slot_table #(
  parameter int DEPTH = 10
) (
  input  logic                    clk,
  input  smam_pkg::tbl_cmd_t      cmd,
  input  logic [smam_pkg::IDX_W-1:0] rd_addr,
  output smam_pkg::slot_t         rd_data
);
  import smam_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  slot_t slots [DEPTH];

  logic wr_hit;
  logic rd_hit;

  assign wr_hit = (cmd.addr < IDX_W'(DEPTH));
  assign rd_hit = (rd_addr < IDX_W'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      if (cmd.wr_slot) begin
        slots[cmd.addr[AW-1:0]] <= cmd.data;
      end else if (cmd.wr_en_bit) begin
        slots[cmd.addr[AW-1:0]].enable <= cmd.en_bit;
      end
    end
  end

  // Beyond the table reads as an empty, disabled slot.
  always_comb begin
    rd_data = '0;
    if (rd_hit) begin
      rd_data = slots[rd_addr[AW-1:0]];
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Alarm matcher testbench
// Drives add, delete, enable, disable, time check and dismiss items through
// the start/busy handshake and checks every done strobe against a typed result
// or a model of the slot table: a directed table first, then weighted random items.
// ----------------------------------------------------------------------------
module testbench;
  import smam_pkg::*;

  localparam int HALF_PERIOD     = 4;
  localparam int TABLE_DEPTH     = 10;
  localparam int RANDOM_ITEMS    = 350;
  localparam int IDLE_PCT        = 29;
  localparam int QUIET_FROM      = 100;  // random items in [QUIET_FROM, QUIET_TO) never idle
  localparam int QUIET_TO        = 200;
  localparam int DRAIN_AT        = 250;  // sender waits for an empty pipe before this item
  localparam int SETTLE_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PRINT_LIMIT     = 50;

  // Codes 6 and 7 have no function; the block must leave its state alone.
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  idx;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic              en;
    logic              rpt;
  } alarm_item_t;

  typedef struct {
    logic [STAT_W-1:0] status;
    logic              alert;
    logic [IDX_W-1:0]  fired;
    logic [CNT_W-1:0]  used;
  } alarm_result_t;

  typedef struct {
    alarm_item_t   item;
    bit            fixed;  // use the typed result instead of the model's
    alarm_result_t want;
  } stim_row_t;

  // DUT ports
  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OP_W-1:0]     operation;
  logic [IDX_W-1:0]    slot_index;
  logic [HOUR_W-1:0]   hour_value;
  logic [MIN_W-1:0]    minute_value;
  logic [SEC_W-1:0]    second_value;
  logic                new_enabled;
  logic                new_repeat;
  logic                done;
  logic [STAT_W-1:0]   status;
  logic                alert_on;
  logic [IDX_W-1:0]    fired_slot;
  logic [CNT_W-1:0]    used_slots;

  // Item on the pins, with its typed result where the row carries one.
  alarm_item_t   drive_item;
  bit            drive_fixed;
  alarm_result_t drive_want;

  // Local copy of the slot table and alert state.
  logic [HOUR_W-1:0] tbl_hour   [TABLE_DEPTH] = '{default: '0};
  logic [MIN_W-1:0]  tbl_minute [TABLE_DEPTH] = '{default: '0};
  logic [SEC_W-1:0]  tbl_second [TABLE_DEPTH] = '{default: '0};
  logic              tbl_enable [TABLE_DEPTH] = '{default: 1'b0};
  logic              tbl_repeat [TABLE_DEPTH] = '{default: 1'b0};
  logic [CNT_W-1:0]  tbl_used    = '0;
  logic              alert_flag  = 1'b0;
  logic [IDX_W-1:0]  alert_idx   = NO_SLOT;

  alarm_result_t pending_results [$];
  int            mismatches   = 0;
  int            results_seen = 0;
  int            stall_cycles = 0;

  assign operation    = drive_item.op;
  assign slot_index   = drive_item.idx;
  assign hour_value   = drive_item.hour;
  assign minute_value = drive_item.minute;
  assign second_value = drive_item.second;
  assign new_enabled  = drive_item.en;
  assign new_repeat   = drive_item.rpt;

  multi_slot_alarm_matcher #(
    .SLOT_COUNT_MAX(TABLE_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .slot_index   (slot_index),
    .hour_value   (hour_value),
    .minute_value (minute_value),
    .second_value (second_value),
    .new_enabled  (new_enabled),
    .new_repeat   (new_repeat),
    .done         (done),
    .status       (status),
    .alert_on     (alert_on),
    .fired_slot   (fired_slot),
    .used_slots   (used_slots)
  );

  always #(HALF_PERIOD) clk = ~clk;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  // Advance the local table by one item and return the result it should give.
  task automatic alarm_step(input alarm_item_t it, output alarm_result_t res);
    int                cnt;
    bit                in_range;
    logic [STAT_W-1:0] st;
    cnt      = int'(tbl_used);
    in_range = int'(it.idx) < cnt;
    st       = STAT_DONE;
    case (it.op)
      OP_ADD: begin
        if (cnt >= TABLE_DEPTH) begin
          st = STAT_FULL;
        end else begin
          // Append at the end; time fields are kept at full width.
          tbl_hour[cnt]   = it.hour;
          tbl_minute[cnt] = it.minute;
          tbl_second[cnt] = it.second;
          tbl_enable[cnt] = it.en;
          tbl_repeat[cnt] = it.rpt;
          tbl_used        = tbl_used + 1'b1;
        end
      end
      OP_DELETE: begin
        if (!in_range) begin
          st = STAT_RANGE;
        end else begin
          // Close the gap: shift later slots down. The alert slot number stays.
          for (int k = int'(it.idx); k + 1 < cnt; k++) begin
            tbl_hour[k]   = tbl_hour[k+1];
            tbl_minute[k] = tbl_minute[k+1];
            tbl_second[k] = tbl_second[k+1];
            tbl_enable[k] = tbl_enable[k+1];
            tbl_repeat[k] = tbl_repeat[k+1];
          end
          tbl_used = tbl_used - 1'b1;
        end
      end
      OP_ENABLE, OP_DISABLE: begin
        if (!in_range) begin
          st = STAT_RANGE;
        end else begin
          tbl_enable[it.idx] = (it.op == OP_ENABLE);
        end
      end
      OP_CHECK: begin
        // Skip while an alert is up; else the lowest enabled exact match fires.
        if (!alert_flag) begin
          for (int k = 0; k < cnt; k++) begin
            if (tbl_enable[k] && tbl_hour[k] == it.hour &&
                tbl_minute[k] == it.minute && tbl_second[k] == it.second) begin
              alert_flag = 1'b1;
              alert_idx  = IDX_W'(k);
              if (!tbl_repeat[k]) begin
                tbl_enable[k] = 1'b0;
              end
              break;
            end
          end
        end
      end
      OP_DISMISS: begin
        alert_flag = 1'b0;
        alert_idx  = NO_SLOT;
      end
      default: begin
      end
    endcase
    res.status = st;
    res.alert  = alert_flag;
    res.fired  = alert_idx;
    res.used   = tbl_used;
  endtask

  function automatic stim_row_t stim_row(
    logic [OP_W-1:0] op, int idx, int hr, int mn, int sc, bit en, bit rp,
    bit fixed = 1'b0, int st = 0, int al = 0, int fs = 0, int us = 0
  );
    stim_row_t r;
    r.item.op     = op;
    r.item.idx    = IDX_W'(idx);
    r.item.hour   = HOUR_W'(hr);
    r.item.minute = MIN_W'(mn);
    r.item.second = SEC_W'(sc);
    r.item.en     = en;
    r.item.rpt    = rp;
    r.fixed       = fixed;
    r.want.status = STAT_W'(st);
    r.want.alert  = al[0];
    r.want.fired  = IDX_W'(fs);
    r.want.used   = CNT_W'(us);
    return r;
  endfunction

  // Present one item; call at a falling edge. Idle at random first, then hold
  // start high until the block takes the item.
  task automatic send_item(input alarm_item_t it, input bit fixed,
                           input alarm_result_t want, input bit may_idle);
    while (may_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    drive_item  = it;
    drive_fixed = fixed;
    drive_want  = want;
    start <= 1'b1;
    @(posedge clk);
    while (!(start && !busy)) @(posedge clk);
  endtask

  // Sample at the rising edge: retire a result first, then log a new item.
  always @(posedge clk) begin : result_monitor
    alarm_result_t want;
    alarm_result_t predicted;
    bit            progress;
    if (!rst) begin
      progress = 1'b0;
      if (done) begin
        progress = 1'b1;
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
        end else begin
          want = pending_results.pop_front();
          if (status !== want.status) begin
            report_mismatch($sformatf("result %0d status %0d, want %0d",
                                      results_seen, status, want.status));
          end
          if (alert_on !== want.alert) begin
            report_mismatch($sformatf("result %0d alert_on %0d, want %0d",
                                      results_seen, alert_on, want.alert));
          end
          if (fired_slot !== want.fired) begin
            report_mismatch($sformatf("result %0d fired_slot %0d, want %0d",
                                      results_seen, fired_slot, want.fired));
          end
          if (used_slots !== want.used) begin
            report_mismatch($sformatf("result %0d used_slots %0d, want %0d",
                                      results_seen, used_slots, want.used));
          end
        end
      end
      if (start && !busy) begin
        progress = 1'b1;
        alarm_step(drive_item, predicted);
        if (drive_fixed) begin
          pending_results.push_back(drive_want);
        end else begin
          pending_results.push_back(predicted);
        end
      end
      // Watchdog: count cycles in which nothing moves either way.
      if (progress) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    stim_row_t     directed [$];
    alarm_item_t   it;
    alarm_result_t none;
    int            cnt;
    int            pick;
    int            r;
    int            add_w;
    int            del_w;
    int            issued;
    int            sent;

    rst         = 1'b1;
    start       = 1'b0;
    drive_item  = '{default: '0};
    drive_fixed = 1'b0;
    drive_want  = '{default: '0};
    none        = '{default: '0};

    // Directed table. Typed results only where they are plain to see.
    // Idle block: dismiss and an out-of-range delete on an empty table.
    directed.push_back(stim_row(OP_DISMISS, 0, 0, 0, 0, 0, 0,
                                1, STAT_DONE, 0, NO_SLOT, 0));
    directed.push_back(stim_row(OP_DELETE, 0, 0, 0, 0, 0, 0,
                                1, STAT_RANGE, 0, NO_SLOT, 0));
    // Time extremes, including values past the legal range.
    directed.push_back(stim_row(OP_ADD, 0, 23, 59, 59, 1, 0,
                                1, STAT_DONE, 0, NO_SLOT, 1));
    directed.push_back(stim_row(OP_ADD, 15, 31, 63, 63, 1, 1,
                                1, STAT_DONE, 0, NO_SLOT, 2));
    directed.push_back(stim_row(OP_ADD, 0, 0, 0, 0, 0, 1,
                                1, STAT_DONE, 0, NO_SLOT, 3));
    // One-shot slot fires, check during alert is ignored, then it stays off.
    directed.push_back(stim_row(OP_CHECK, 0, 23, 59, 59, 0, 0,
                                1, STAT_DONE, 1, 0, 3));
    directed.push_back(stim_row(OP_CHECK, 0, 31, 63, 63, 0, 0,
                                1, STAT_DONE, 1, 0, 3));
    directed.push_back(stim_row(OP_DISMISS, 0, 0, 0, 0, 0, 0,
                                1, STAT_DONE, 0, NO_SLOT, 3));
    directed.push_back(stim_row(OP_CHECK, 0, 23, 59, 59, 0, 0,
                                1, STAT_DONE, 0, NO_SLOT, 3));
    // Daily slot fires; deleting below it leaves the alert slot number alone.
    directed.push_back(stim_row(OP_CHECK, 0, 31, 63, 63, 0, 0,
                                1, STAT_DONE, 1, 1, 3));
    directed.push_back(stim_row(OP_DELETE, 0, 0, 0, 0, 0, 0,
                                1, STAT_DONE, 1, 1, 2));
    directed.push_back(stim_row(OP_DISMISS, 0, 0, 0, 0, 0, 0,
                                1, STAT_DONE, 0, NO_SLOT, 2));
    directed.push_back(stim_row(OP_ENABLE, 1, 0, 0, 0, 0, 0));
    // Index at the top of the field and index equal to the used count.
    directed.push_back(stim_row(OP_DISABLE, 15, 0, 0, 0, 0, 0,
                                1, STAT_RANGE, 0, NO_SLOT, 2));
    directed.push_back(stim_row(OP_ENABLE, 2, 0, 0, 0, 0, 0,
                                1, STAT_RANGE, 0, NO_SLOT, 2));
    directed.push_back(stim_row(OP_CHECK, 0, 0, 0, 0, 0, 0));
    directed.push_back(stim_row(OP_UNUSED_HI, 9, 17, 33, 44, 1, 1));
    // Fill the table, then one add too many.
    directed.push_back(stim_row(OP_ADD, 0, 1, 2, 3, 1, 0));
    directed.push_back(stim_row(OP_ADD, 0, 12, 30, 0, 0, 1));
    directed.push_back(stim_row(OP_ADD, 0, 7, 45, 15, 1, 1));
    directed.push_back(stim_row(OP_ADD, 0, 23, 0, 59, 1, 0));
    directed.push_back(stim_row(OP_ADD, 0, 16, 32, 32, 0, 0));
    directed.push_back(stim_row(OP_ADD, 0, 5, 5, 5, 1, 1));
    directed.push_back(stim_row(OP_ADD, 0, 20, 40, 20, 1, 0));
    directed.push_back(stim_row(OP_ADD, 0, 0, 59, 1, 0, 1));
    directed.push_back(stim_row(OP_ADD, 0, 9, 9, 9, 1, 1,
                                1, STAT_FULL, 1, 1, TABLE_DEPTH));

    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      @(negedge clk);
      send_item(directed[i].item, directed[i].fixed, directed[i].want, 1'b1);
    end

    // Random part. Ops are weighted to keep the table moving between empty
    // and full, and most checks reuse a stored time so alerts really fire.
    issued = 0;
    sent   = 0;
    while (issued < RANDOM_ITEMS) begin
      @(negedge clk);
      if (sent == DRAIN_AT) begin
        // Hold off until every outstanding result is back.
        start <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      cnt   = int'(tbl_used);
      add_w = (cnt >= TABLE_DEPTH - 1) ? 6 : 20;
      del_w = (cnt >= TABLE_DEPTH - 3) ? 16 : 8;
      r     = $urandom_range(0, 99);
      if (r < add_w) begin
        it.op = OP_ADD;
      end else if (r < add_w + del_w) begin
        it.op = OP_DELETE;
      end else if (r < add_w + del_w + 10) begin
        it.op = OP_ENABLE;
      end else if (r < add_w + del_w + 18) begin
        it.op = OP_DISABLE;
      end else if (r < add_w + del_w + 50) begin
        it.op = OP_CHECK;
      end else if (r < add_w + del_w + 66) begin
        it.op = OP_DISMISS;
      end else begin
        it.op = ($urandom_range(0, 1) != 0) ? OP_UNUSED_HI : OP_UNUSED_LO;
      end
      // Mostly a slot in use; sometimes anything the field can hold.
      if (cnt > 0 && $urandom_range(0, 99) < 85) begin
        it.idx = IDX_W'($urandom_range(0, cnt - 1));
      end else begin
        it.idx = IDX_W'($urandom_range(0, 15));
      end
      if (it.op == OP_CHECK && cnt > 0 && $urandom_range(0, 99) < 65) begin
        pick      = $urandom_range(0, cnt - 1);
        it.hour   = tbl_hour[pick];
        it.minute = tbl_minute[pick];
        it.second = tbl_second[pick];
      end else if ($urandom_range(0, 99) < 80) begin
        it.hour   = HOUR_W'($urandom_range(0, 23));
        it.minute = MIN_W'($urandom_range(0, 59));
        it.second = SEC_W'($urandom_range(0, 59));
      end else begin
        it.hour   = HOUR_W'($urandom_range(0, 31));
        it.minute = MIN_W'($urandom_range(0, 63));
        it.second = SEC_W'($urandom_range(0, 63));
      end
      it.en  = ($urandom_range(0, 99) < 75);
      it.rpt = 1'($urandom_range(0, 1));
      send_item(it, 1'b0, none, !(sent >= QUIET_FROM && sent < QUIET_TO));
      if (it.op != OP_UNUSED_LO && it.op != OP_UNUSED_HI) begin
        issued++;
      end
      sent++;
    end

    // Drop start, drain the pipe, then watch a little longer for strays.
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
